// ----- rtl/core/ipid_pkg.sv -----
// Shared types and constants for the four-motor incremental PID speed loop.
// Used by the register file, the motor lanes and the top level; no dependencies.
`default_nettype none

package ipid_pkg;

  // Number of motors served by one item; the item layout below is built for it.
  localparam int MOTOR_COUNT = 4;

  // Default number of fraction bits in the gains and in the accumulator.
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int SPEED_W = 16;
  localparam int DRIVE_W = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DIFF_W  = SPEED_W + 3;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] OUTPUT_MAX_RESET = LIMIT_W'(16384);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = 2'd0,
    REG_KI         = 2'd1,
    REG_KD         = 2'd2,
    REG_OUTPUT_MAX = 2'd3
  } cfg_reg_e;

  // One input item: target and measured speed of every motor.
  typedef struct packed {
    logic signed [SPEED_W-1:0] setpoint_0;
    logic signed [SPEED_W-1:0] setpoint_1;
    logic signed [SPEED_W-1:0] setpoint_2;
    logic signed [SPEED_W-1:0] setpoint_3;
    logic signed [SPEED_W-1:0] measured_0;
    logic signed [SPEED_W-1:0] measured_1;
    logic signed [SPEED_W-1:0] measured_2;
    logic signed [SPEED_W-1:0] measured_3;
  } speed_t;

  // One result item: drive output of every motor.
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_0;
    logic signed [DRIVE_W-1:0] drive_1;
    logic signed [DRIVE_W-1:0] drive_2;
    logic signed [DRIVE_W-1:0] drive_3;
  } drive_t;

  // Gains and limit shared by all lanes.
  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] output_max;
  } gains_t;

  // Pipeline strobes from the control logic to the lanes.
  typedef struct packed {
    logic accept;
    logic advance;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipid_regs.sv -----
// Configuration registers of the incremental PID loop: gains and output limit.
// Depends on ipid_pkg for the register indexes and the gains_t type.
`default_nettype none

module ipid_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ipid_pkg::gains_t                        gains
);

  // Decode the index and keep the written value, masked to the register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp         <= '0;
      gains.ki         <= '0;
      gains.kd         <= '0;
      gains.output_max <= ipid_pkg::OUTPUT_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ipid_pkg::REG_KP:         gains.kp <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_KI:         gains.ki <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_KD:         gains.kd <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_OUTPUT_MAX: gains.output_max <= cfg_data[ipid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ipid_lane.sv -----
// One motor lane of the incremental PID loop: error history, gain products
// and the saturating output accumulator. Depends on ipid_pkg.
`default_nettype none

module ipid_lane #(
  parameter int GAIN_FRAC_BITS = ipid_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire ipid_pkg::lane_ctrl_t                  ctrl,
  input  wire ipid_pkg::gains_t                      gains,
  input  wire logic signed [ipid_pkg::SPEED_W-1:0]   setpoint,
  input  wire logic signed [ipid_pkg::SPEED_W-1:0]   measured,
  output logic signed [ipid_pkg::DRIVE_W-1:0]        drive
);

  localparam int ERR_W  = ipid_pkg::ERR_W;
  localparam int DIFF_W = ipid_pkg::DIFF_W;
  localparam int PROD_W = ipid_pkg::PROD_W;
  localparam int ACC_W  = ERR_W + GAIN_FRAC_BITS;
  localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 2;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ERR_W-1:0]  older_err;
  logic signed [DIFF_W-1:0] diff1;
  logic signed [DIFF_W-1:0] diff2;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  acc_shifted;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  limit;

  // Error and its first and second differences, all exact.
  assign err   = ERR_W'(setpoint) - ERR_W'(measured);
  assign diff1 = DIFF_W'(err) - DIFF_W'(prev_err);
  assign diff2 = DIFF_W'(err) - (DIFF_W'(prev_err) <<< 1) + DIFF_W'(older_err);

  // Error history shifts as each item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err  <= '0;
      older_err <= '0;
    end else if (ctrl.accept) begin
      prev_err  <= err;
      older_err <= prev_err;
    end
  end

  // Gain products, registered ahead of the accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      prod_p <= $signed({1'b0, gains.kp}) * diff1;
      prod_i <= $signed({1'b0, gains.ki}) * DIFF_W'(err);
      prod_d <= $signed({1'b0, gains.kd}) * diff2;
    end
  end

  // Weighted increment added to the running output, then clamped to the limit.
  assign limit = $signed(SUM_W'(gains.output_max) << GAIN_FRAC_BITS);
  assign sum   = SUM_W'(acc) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  always_comb begin
    if (sum > limit) begin
      acc_next = ACC_W'(limit);
    end else if (sum < -limit) begin
      acc_next = ACC_W'(-limit);
    end else begin
      acc_next = ACC_W'(sum);
    end
  end

  // The drive is the floor of the accumulator, its fraction bits dropped.
  assign acc_shifted = acc_next >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.advance) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      drive <= acc_shifted[ipid_pkg::DRIVE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/incremental_pid_four_motor.sv -----
// Incremental PID speed loop for four motors: top level with handshake control,
// configuration registers, the four motor lanes and the result merge.
// Depends on ipid_pkg, ipid_regs and ipid_lane.
//
// Each input item carries target and measured speed for all four motors; each
// result item carries the four clamped drive outputs. One item is accepted per
// clock cycle when the result side keeps up. The first stage forms the errors and
// the three gain products per motor (one registered multiplier each), the second
// adds them to the accumulator, clamps it and registers the drive. The accumulator
// update in the second stage is the only loop carried from item to item. Gains
// and the output limit are written through cfg_write/cfg_index/cfg_data; the
// user must do so only while no item is in flight; the block does not enforce it.
`default_nettype none

module incremental_pid_four_motor #(
  parameter int GAIN_FRAC_BITS = ipid_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              speed_valid,
  output logic                                   speed_stall,
  input  wire ipid_pkg::speed_t                  speed,
  output logic                                   drive_valid,
  input  wire logic                              drive_stall,
  output ipid_pkg::drive_t                       drive,
  input  wire logic                              cfg_write,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int N = ipid_pkg::MOTOR_COUNT;

  ipid_pkg::gains_t     gains;
  ipid_pkg::lane_ctrl_t ctrl;
  logic                 prod_valid;
  logic signed [ipid_pkg::SPEED_W-1:0] setpoint [N];
  logic signed [ipid_pkg::SPEED_W-1:0] measured [N];
  logic signed [ipid_pkg::DRIVE_W-1:0] lane_drive [N];

  ipid_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  // The product stage moves on when the result register is empty or being taken.
  assign ctrl.advance = prod_valid && (!drive_valid || !drive_stall);
  assign speed_stall  = prod_valid && !ctrl.advance;
  assign ctrl.accept  = speed_valid && !speed_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.accept) begin
      prod_valid <= 1'b1;
    end else if (ctrl.advance) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (ctrl.advance) begin
      drive_valid <= 1'b1;
    end else if (!drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  // Split the item into per-motor operands.
  assign setpoint[0] = speed.setpoint_0;
  assign setpoint[1] = speed.setpoint_1;
  assign setpoint[2] = speed.setpoint_2;
  assign setpoint[3] = speed.setpoint_3;
  assign measured[0] = speed.measured_0;
  assign measured[1] = speed.measured_1;
  assign measured[2] = speed.measured_2;
  assign measured[3] = speed.measured_3;

  for (genvar m = 0; m < N; m++) begin : g_lane
    ipid_lane #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .gains    (gains),
      .setpoint (setpoint[m]),
      .measured (measured[m]),
      .drive    (lane_drive[m])
    );
  end

  // Merge the lane outputs into one result item.
  assign drive.drive_0 = lane_drive[0];
  assign drive.drive_1 = lane_drive[1];
  assign drive.drive_2 = lane_drive[2];
  assign drive.drive_3 = lane_drive[3];

endmodule

`default_nettype wire
